/* rtl/vfc_pkg.sv */
// Shared types and constants for the viewport fit and crop pipeline.
// Has no dependencies. Both vfc_div and viewport_fit_crop import it.
package vfc_pkg;

  localparam int SRC_W   = 14;
  localparam int COORD_W = 22;
  localparam int PAN_W   = 17;
  localparam int ALIGN_W = 19;
  localparam int SCALE_W = 24;
  localparam int CFG_W   = 24;
  localparam int NUM_W   = 38;
  localparam int Q16     = 16;

  localparam logic [PAN_W-1:0]   ONE_Q16   = PAN_W'(65536);
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  typedef enum logic [1:0] {
    REG_REF_WIDTH  = 2'd0,
    REG_REF_HEIGHT = 2'd1,
    REG_ZOOM       = 2'd2
  } vfc_reg_t;

  typedef struct packed {
    logic                 degen;
    logic                 zmode;
    logic [SRC_W-1:0]     sw;
    logic [SRC_W-1:0]     sh;
    logic [COORD_W-1:0]   pl;
    logic [COORD_W-1:0]   pt;
    logic [COORD_W-1:0]   pr;
    logic [COORD_W-1:0]   pb;
    logic [COORD_W-1:0]   pw;
    logic [COORD_W-1:0]   ph;
    logic [PAN_W-1:0]     panx;
    logic [PAN_W-1:0]     pany;
    logic [PAN_W-1:0]     ax;
    logic [PAN_W-1:0]     ay;
    logic [SCALE_W-1:0]   scale;
  } vfc_item_t;

  function automatic logic [PAN_W-1:0] clamp_align(input logic signed [ALIGN_W-1:0] a);
    logic [PAN_W-1:0] r;
    if (a < 0) r = '0;
    else if (a > $signed({2'b00, ONE_Q16})) r = ONE_Q16;
    else r = a[PAN_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/vfc_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Carries a vfc_pkg::vfc_item_t alongside each word.
module vfc_div #(
  parameter int NW = 38,
  parameter int DW = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NW-1:0]       in_num_x,
  input  logic [NW-1:0]       in_num_y,
  input  logic [DW-1:0]       in_den_x,
  input  logic [DW-1:0]       in_den_y,
  input  vfc_pkg::vfc_item_t  in_item,
  output logic                out_valid,
  output logic [NW-1:0]       out_quo_x,
  output logic [NW-1:0]       out_quo_y,
  output vfc_pkg::vfc_item_t  out_item
);
  import vfc_pkg::*;

  logic            valid_r [NW];
  logic [DW-1:0]   rx_r [NW];
  logic [DW-1:0]   ry_r [NW];
  logic [DW-1:0]   dx_r [NW];
  logic [DW-1:0]   dy_r [NW];
  logic [NW-1:0]   qx_r [NW];
  logic [NW-1:0]   qy_r [NW];
  vfc_item_t       item_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            v_in;
    logic [DW-1:0]   rx_in, ry_in, dx_in, dy_in;
    logic [NW-1:0]   qx_in, qy_in;
    vfc_item_t       it_in;
    logic [DW:0]     tx, ty;
    logic            gx, gy;
    logic [DW-1:0]   rx_nxt, ry_nxt;
    logic [NW-1:0]   qx_nxt, qy_nxt;

    if (k == 0) begin : g_first
      assign v_in  = in_valid;
      assign rx_in = '0;
      assign ry_in = '0;
      assign dx_in = in_den_x;
      assign dy_in = in_den_y;
      assign qx_in = in_num_x;
      assign qy_in = in_num_y;
      assign it_in = in_item;
    end else begin : g_next
      assign v_in  = valid_r[k-1];
      assign rx_in = rx_r[k-1];
      assign ry_in = ry_r[k-1];
      assign dx_in = dx_r[k-1];
      assign dy_in = dy_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
      assign it_in = item_r[k-1];
    end

    always_comb begin
      tx     = {rx_in, qx_in[NW-1]};
      ty     = {ry_in, qy_in[NW-1]};
      gx     = tx >= {1'b0, dx_in};
      gy     = ty >= {1'b0, dy_in};
      rx_nxt = gx ? DW'(tx - {1'b0, dx_in}) : tx[DW-1:0];
      ry_nxt = gy ? DW'(ty - {1'b0, dy_in}) : ty[DW-1:0];
      qx_nxt = {qx_in[NW-2:0], gx};
      qy_nxt = {qy_in[NW-2:0], gy};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k]   <= rx_nxt;
        ry_r[k]   <= ry_nxt;
        dx_r[k]   <= dx_in;
        dy_r[k]   <= dy_in;
        qx_r[k]   <= qx_nxt;
        qy_r[k]   <= qy_nxt;
        item_r[k] <= it_in;
      end
    end
  end

  assign out_valid = valid_r[NW-1];
  assign out_quo_x = qx_r[NW-1];
  assign out_quo_y = qy_r[NW-1];
  assign out_item  = item_r[NW-1];

endmodule

/* rtl/viewport_fit_crop.sv */
// Viewport fit and crop: places a source frame in a pane and returns the source crop,
// the placed target rectangle and the Q8.16 scale. One word is taken every cycle while the
// output is not stalled; the pipeline is the two chained 38-stage dividers (scale, then
// visible extent) plus seven arithmetic and output stages. The whole pipeline holds
// while a finished word waits at the output. Depends on vfc_pkg, vfc_div.
module viewport_fit_crop #(
  parameter int MAX_DIM         = 16384,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [vfc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vfc_pkg::SRC_W-1:0]      in_src_width,
  input  logic [vfc_pkg::SRC_W-1:0]      in_src_height,
  input  logic [vfc_pkg::COORD_W-1:0]    in_pane_left,
  input  logic [vfc_pkg::COORD_W-1:0]    in_pane_top,
  input  logic [vfc_pkg::COORD_W-1:0]    in_pane_right,
  input  logic [vfc_pkg::COORD_W-1:0]    in_pane_bottom,
  input  logic [vfc_pkg::PAN_W-1:0]      in_pan_centre_x,
  input  logic [vfc_pkg::PAN_W-1:0]      in_pan_centre_y,
  input  logic signed [vfc_pkg::ALIGN_W-1:0] in_slack_align_x,
  input  logic signed [vfc_pkg::ALIGN_W-1:0] in_slack_align_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vfc_pkg::COORD_W-1:0]    out_crop_left,
  output logic [vfc_pkg::COORD_W-1:0]    out_crop_top,
  output logic [vfc_pkg::COORD_W-1:0]    out_crop_right,
  output logic [vfc_pkg::COORD_W-1:0]    out_crop_bottom,
  output logic [vfc_pkg::COORD_W-1:0]    out_target_left,
  output logic [vfc_pkg::COORD_W-1:0]    out_target_top,
  output logic [vfc_pkg::COORD_W-1:0]    out_target_right,
  output logic [vfc_pkg::COORD_W-1:0]    out_target_bottom,
  output logic [vfc_pkg::SCALE_W-1:0]    out_screen_scale
);
  import vfc_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int SF_W  = SRC_W + F;
  localparam int PS_W  = SF_W + 1;
  localparam int SX_W  = SF_W + 3;

  logic en;

  // configuration
  logic [SRC_W-1:0]   ref_w_r, ref_h_r;
  logic [SCALE_W-1:0] zoom_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_w_r <= '0;
      ref_h_r <= '0;
      zoom_r  <= '0;
    end else if (cfg_valid) begin
      case (vfc_reg_t'(cfg_index))
        REG_REF_WIDTH:  ref_w_r <= cfg_data[SRC_W-1:0];
        REG_REF_HEIGHT: ref_h_r <= cfg_data[SRC_W-1:0];
        REG_ZOOM:       zoom_r  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: capture, scale numerators
  logic [SRC_W-1:0]   sw_m, sh_m, rw_sel;
  logic [COORD_W:0]   pw_d, ph_d;
  vfc_item_t          it0_nxt, s0_item_r;
  logic [NUM_W-1:0]   nx0_nxt, ny0_nxt, s0_nx_r, s0_ny_r;
  logic               s0_valid_r;

  always_comb begin
    sw_m   = in_src_width & SRC_W'(MAX_DIM - 1);
    sh_m   = in_src_height & SRC_W'(MAX_DIM - 1);
    pw_d   = {1'b0, in_pane_right} - {1'b0, in_pane_left};
    ph_d   = {1'b0, in_pane_bottom} - {1'b0, in_pane_top};
    rw_sel = (ref_w_r == '0 || ref_h_r == '0) ? sw_m : ref_w_r;
    it0_nxt.degen = (sw_m == '0) || (sh_m == '0) || pw_d[COORD_W] || (pw_d == '0)
                    || ph_d[COORD_W] || (ph_d == '0);
    it0_nxt.zmode = zoom_r != '0;
    it0_nxt.sw    = sw_m;
    it0_nxt.sh    = sh_m;
    it0_nxt.pl    = in_pane_left;
    it0_nxt.pt    = in_pane_top;
    it0_nxt.pr    = in_pane_right;
    it0_nxt.pb    = in_pane_bottom;
    it0_nxt.pw    = pw_d[COORD_W-1:0];
    it0_nxt.ph    = ph_d[COORD_W-1:0];
    it0_nxt.panx  = in_pan_centre_x;
    it0_nxt.pany  = in_pan_centre_y;
    it0_nxt.ax    = clamp_align(in_slack_align_x);
    it0_nxt.ay    = clamp_align(in_slack_align_y);
    it0_nxt.scale = '0;
    nx0_nxt = it0_nxt.zmode ? NUM_W'(zoom_r) * NUM_W'(rw_sel)
                            : NUM_W'(it0_nxt.pw) << (Q16 - F);
    ny0_nxt = NUM_W'(it0_nxt.ph) << (Q16 - F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item_r <= it0_nxt;
      s0_nx_r   <= nx0_nxt;
      s0_ny_r   <= ny0_nxt;
    end
  end

  // scale division
  logic             a_valid;
  logic [NUM_W-1:0] qa_x, qa_y;
  vfc_item_t        a_item;

  vfc_div #(.NW(NUM_W), .DW(SRC_W)) u_div_scale (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s0_valid_r), .in_num_x(s0_nx_r), .in_num_y(s0_ny_r),
    .in_den_x(s0_item_r.sw), .in_den_y(s0_item_r.sh), .in_item(s0_item_r),
    .out_valid(a_valid), .out_quo_x(qa_x), .out_quo_y(qa_y), .out_item(a_item)
  );

  // stage 2: pick and saturate scale
  logic [NUM_W-1:0] qsel;
  vfc_item_t        it2_nxt, s2_item_r;
  logic             s2_valid_r;

  always_comb begin
    qsel = (a_item.zmode || qa_x < qa_y) ? qa_x : qa_y;
    it2_nxt = a_item;
    if (qsel > NUM_W'(SCALE_MAX)) it2_nxt.scale = SCALE_MAX;
    else if (qsel == '0) it2_nxt.scale = SCALE_W'(1);
    else it2_nxt.scale = qsel[SCALE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (en) s2_valid_r <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) s2_item_r <= it2_nxt;
  end

  // visible extent division
  logic             b_valid;
  logic [NUM_W-1:0] qb_x, qb_y;
  vfc_item_t        b_item;

  vfc_div #(.NW(NUM_W), .DW(SCALE_W)) u_div_vis (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s2_valid_r),
    .in_num_x(NUM_W'(s2_item_r.pw) << Q16), .in_num_y(NUM_W'(s2_item_r.ph) << Q16),
    .in_den_x(s2_item_r.scale), .in_den_y(s2_item_r.scale), .in_item(s2_item_r),
    .out_valid(b_valid), .out_quo_x(qb_x), .out_quo_y(qb_y), .out_item(b_item)
  );

  // stage 3: clamp visible extent
  logic [SF_W-1:0] swf3, shf3, vw3_nxt, vh3_nxt, s3_vw_r, s3_vh_r;
  vfc_item_t       s3_item_r;
  logic            s3_valid_r;

  always_comb begin
    swf3    = SF_W'(b_item.sw) << F;
    shf3    = SF_W'(b_item.sh) << F;
    vw3_nxt = (qb_x > NUM_W'(swf3)) ? swf3 : SF_W'(qb_x);
    vh3_nxt = (qb_y > NUM_W'(shf3)) ? shf3 : SF_W'(qb_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else if (en) s3_valid_r <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_item_r <= b_item;
      s3_vw_r   <= vw3_nxt;
      s3_vh_r   <= vh3_nxt;
    end
  end

  // stage 4: pan position and target size
  logic [SF_W-1:0]    swf4, shf4;
  logic [PS_W-1:0]    psx4_nxt, psy4_nxt, s4_psx_r, s4_psy_r;
  logic [COORD_W-1:0] tw4_nxt, th4_nxt, s4_tw_r, s4_th_r;
  logic [SF_W-1:0]    s4_vw_r, s4_vh_r;
  vfc_item_t          s4_item_r;
  logic               s4_valid_r;

  always_comb begin
    swf4     = SF_W'(s3_item_r.sw) << F;
    shf4     = SF_W'(s3_item_r.sh) << F;
    psx4_nxt = PS_W'(((PAN_W + SF_W)'(s3_item_r.panx) * (PAN_W + SF_W)'(swf4)) >> Q16);
    psy4_nxt = PS_W'(((PAN_W + SF_W)'(s3_item_r.pany) * (PAN_W + SF_W)'(shf4)) >> Q16);
    tw4_nxt  = COORD_W'(((SF_W + SCALE_W)'(s3_vw_r) * (SF_W + SCALE_W)'(s3_item_r.scale))
                        >> Q16);
    th4_nxt  = COORD_W'(((SF_W + SCALE_W)'(s3_vh_r) * (SF_W + SCALE_W)'(s3_item_r.scale))
                        >> Q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_valid_r <= 1'b0;
    else if (en) s4_valid_r <= s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_item_r <= s3_item_r;
      s4_vw_r   <= s3_vw_r;
      s4_vh_r   <= s3_vh_r;
      s4_psx_r  <= psx4_nxt;
      s4_psy_r  <= psy4_nxt;
      s4_tw_r   <= tw4_nxt;
      s4_th_r   <= th4_nxt;
    end
  end

  // stage 5: window start with edge clamp, slack
  logic [SF_W-1:0]         swf5, shf5, x05_nxt, y05_nxt, s5_x0_r, s5_y0_r;
  logic signed [SX_W-1:0]  xs5, ys5;
  logic [SX_W-1:0]         xc5, yc5;
  logic [COORD_W-1:0]      s5_slx_r, s5_sly_r, s5_tw_r, s5_th_r;
  logic [SF_W-1:0]         s5_vw_r, s5_vh_r;
  vfc_item_t               s5_item_r;
  logic                    s5_valid_r;

  always_comb begin
    swf5 = SF_W'(s4_item_r.sw) << F;
    shf5 = SF_W'(s4_item_r.sh) << F;
    xs5  = $signed(SX_W'(s4_psx_r)) - $signed(SX_W'(s4_vw_r >> 1));
    ys5  = $signed(SX_W'(s4_psy_r)) - $signed(SX_W'(s4_vh_r >> 1));
    xc5  = xs5[SX_W-1] ? '0 : SX_W'(xs5);
    yc5  = ys5[SX_W-1] ? '0 : SX_W'(ys5);
    x05_nxt = (xc5 + SX_W'(s4_vw_r) > SX_W'(swf5)) ? swf5 - s4_vw_r : SF_W'(xc5);
    y05_nxt = (yc5 + SX_W'(s4_vh_r) > SX_W'(shf5)) ? shf5 - s4_vh_r : SF_W'(yc5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_valid_r <= 1'b0;
    else if (en) s5_valid_r <= s4_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_item_r <= s4_item_r;
      s5_vw_r   <= s4_vw_r;
      s5_vh_r   <= s4_vh_r;
      s5_x0_r   <= x05_nxt;
      s5_y0_r   <= y05_nxt;
      s5_tw_r   <= s4_tw_r;
      s5_th_r   <= s4_th_r;
      s5_slx_r  <= s4_item_r.pw - s4_tw_r;
      s5_sly_r  <= s4_item_r.ph - s4_th_r;
    end
  end

  // stage 6: slack offset, window end, whole-frame test
  logic [COORD_W-1:0] ox6_nxt, oy6_nxt, s6_ox_r, s6_oy_r, s6_tw_r, s6_th_r;
  logic [SF_W-1:0]    s6_x0_r, s6_y0_r;
  logic [SF_W:0]      s6_x1_r, s6_y1_r;
  logic               whole6_nxt, s6_whole_r;
  vfc_item_t          s6_item_r;
  logic               s6_valid_r;

  always_comb begin
    ox6_nxt = COORD_W'(((COORD_W + PAN_W)'(s5_slx_r) * (COORD_W + PAN_W)'(s5_item_r.ax))
                       >> Q16);
    oy6_nxt = COORD_W'(((COORD_W + PAN_W)'(s5_sly_r) * (COORD_W + PAN_W)'(s5_item_r.ay))
                       >> Q16);
    whole6_nxt = (s5_vw_r >= (SF_W'(s5_item_r.sw) << F))
                 && (s5_vh_r >= (SF_W'(s5_item_r.sh) << F));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_valid_r <= 1'b0;
    else if (en) s6_valid_r <= s5_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_item_r  <= s5_item_r;
      s6_ox_r    <= ox6_nxt;
      s6_oy_r    <= oy6_nxt;
      s6_tw_r    <= s5_tw_r;
      s6_th_r    <= s5_th_r;
      s6_x0_r    <= s5_x0_r;
      s6_y0_r    <= s5_y0_r;
      s6_x1_r    <= (SF_W + 1)'(s5_x0_r) + (SF_W + 1)'(s5_vw_r);
      s6_y1_r    <= (SF_W + 1)'(s5_y0_r) + (SF_W + 1)'(s5_vh_r);
      s6_whole_r <= whole6_nxt;
    end
  end

  // output register
  logic               out_valid_r;
  logic [COORD_W-1:0] cl_nxt, ct_nxt, cr_nxt, cb_nxt, tl_nxt, tt_nxt, tr_nxt, tb_nxt;
  logic [COORD_W-1:0] cl_r, ct_r, cr_r, cb_r, tl_r, tt_r, tr_r, tb_r;
  logic [SCALE_W-1:0] sc_nxt, sc_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    cl_nxt = '0;
    ct_nxt = '0;
    cr_nxt = '0;
    cb_nxt = '0;
    if (s6_item_r.degen) begin
      tl_nxt = s6_item_r.pl;
      tt_nxt = s6_item_r.pt;
      tr_nxt = s6_item_r.pr;
      tb_nxt = s6_item_r.pb;
      sc_nxt = SCALE_ONE;
    end else begin
      if (!s6_whole_r) begin
        cl_nxt = COORD_W'(s6_x0_r);
        ct_nxt = COORD_W'(s6_y0_r);
        cr_nxt = COORD_W'(s6_x1_r);
        cb_nxt = COORD_W'(s6_y1_r);
      end
      tl_nxt = s6_item_r.pl + s6_ox_r;
      tt_nxt = s6_item_r.pt + s6_oy_r;
      tr_nxt = s6_item_r.pl + s6_ox_r + s6_tw_r;
      tb_nxt = s6_item_r.pt + s6_oy_r + s6_th_r;
      sc_nxt = s6_item_r.scale;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s6_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl_r <= cl_nxt;
      ct_r <= ct_nxt;
      cr_r <= cr_nxt;
      cb_r <= cb_nxt;
      tl_r <= tl_nxt;
      tt_r <= tt_nxt;
      tr_r <= tr_nxt;
      tb_r <= tb_nxt;
      sc_r <= sc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_crop_left     = cl_r;
  assign out_crop_top      = ct_r;
  assign out_crop_right    = cr_r;
  assign out_crop_bottom   = cb_r;
  assign out_target_left   = tl_r;
  assign out_target_top    = tt_r;
  assign out_target_right  = tr_r;
  assign out_target_bottom = tb_r;
  assign out_screen_scale  = sc_r;

endmodule

/* rtl/vfc_check.sv */
// Port-level assertions for viewport_fit_crop, bound to the top level.
// Depends on vfc_pkg for field widths.
module vfc_check (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [vfc_pkg::COORD_W-1:0]    out_crop_left,
  input logic [vfc_pkg::COORD_W-1:0]    out_crop_top,
  input logic [vfc_pkg::COORD_W-1:0]    out_crop_right,
  input logic [vfc_pkg::COORD_W-1:0]    out_crop_bottom,
  input logic [vfc_pkg::SCALE_W-1:0]    out_screen_scale
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_screen_scale))
    else $error("output word changed while stalled");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_screen_scale != '0)
    else $error("zero scale");

  a_crop_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_crop_left <= out_crop_right) && (out_crop_top <= out_crop_bottom))
    else $error("crop edges out of order");

endmodule

bind viewport_fit_crop vfc_check u_vfc_check (.*);

/* verif/tb.sv */
// Testbench for viewport_fit_crop: random and directed pane requests checked
// against a cycle-free predictor of the scale, crop and target rectangle.
// Depends on vfc_pkg and the viewport_fit_crop RTL.
`timescale 1ns / 100ps

module tb;
  import vfc_pkg::*;

  localparam int FB = 8;
  localparam int LATENCY = 83;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [COORD_W-1:0] cl, ct, cr, cb, tl, tt, tr, tbm;
    logic [SCALE_W-1:0] sc;
  } placement_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [SRC_W-1:0] in_src_width, in_src_height;
  logic [COORD_W-1:0] in_pane_left, in_pane_top, in_pane_right, in_pane_bottom;
  logic [PAN_W-1:0] in_pan_centre_x, in_pan_centre_y;
  logic signed [ALIGN_W-1:0] in_slack_align_x, in_slack_align_y;
  logic [COORD_W-1:0] out_crop_left, out_crop_top, out_crop_right, out_crop_bottom;
  logic [COORD_W-1:0] out_target_left, out_target_top, out_target_right, out_target_bottom;
  logic [SCALE_W-1:0] out_screen_scale;

  longint unsigned ref_w_reg, ref_h_reg, zoom_reg;
  placement_t placements_due[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit gaps_on = 1;

  viewport_fit_crop u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_slack(logic signed [ALIGN_W-1:0] a);
    longint v;
    v = a;
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    return v;
  endfunction

  function automatic longint view_extent(longint pe, longint sf, longint sc);
    longint v;
    v = (pe * 65536) / sc;
    return (v > sf) ? sf : v;
  endfunction

  function automatic longint view_start(longint pan, longint sf, longint v);
    longint s;
    s = ((pan * sf) >>> 16) - (v >>> 1);
    if (s < 0) s = 0;
    if (s + v > sf) s = sf - v;
    return s;
  endfunction

  function automatic placement_t predict_placement();
    placement_t p;
    longint sw, sh, pl, pt, pr, pb, pw, ph, swf, shf, rw, sc, sx, sy;
    longint vw, vh, x0, y0, tw, th, ox, oy;
    sw = in_src_width; sh = in_src_height;
    pl = in_pane_left; pt = in_pane_top; pr = in_pane_right; pb = in_pane_bottom;
    pw = pr - pl; ph = pb - pt;
    p = '0;
    if (sw == 0 || sh == 0 || pw <= 0 || ph <= 0) begin
      p.tl = COORD_W'(pl); p.tt = COORD_W'(pt); p.tr = COORD_W'(pr); p.tbm = COORD_W'(pb);
      p.sc = SCALE_ONE;
      return p;
    end
    swf = sw << FB; shf = sh << FB;
    rw = (ref_w_reg == 0 || ref_h_reg == 0) ? sw : longint'(ref_w_reg);
    if (zoom_reg != 0) begin
      sc = (longint'(zoom_reg) * rw) / sw;
    end else begin
      sx = (pw * 65536) / swf;
      sy = (ph * 65536) / shf;
      sc = (sx < sy) ? sx : sy;
    end
    if (sc < 1) sc = 1;
    if (sc > 24'hFFFFFF) sc = 24'hFFFFFF;
    vw = view_extent(pw, swf, sc);
    vh = view_extent(ph, shf, sc);
    x0 = view_start(in_pan_centre_x, swf, vw);
    y0 = view_start(in_pan_centre_y, shf, vh);
    if (!(vw >= swf && vh >= shf)) begin
      p.cl = COORD_W'(x0); p.ct = COORD_W'(y0);
      p.cr = COORD_W'(x0 + vw); p.cb = COORD_W'(y0 + vh);
    end
    tw = (vw * sc) >>> 16;
    th = (vh * sc) >>> 16;
    ox = ((pw - tw) * clamp_slack(in_slack_align_x)) >>> 16;
    oy = ((ph - th) * clamp_slack(in_slack_align_y)) >>> 16;
    p.tl = COORD_W'(pl + ox); p.tt = COORD_W'(pt + oy);
    p.tr = COORD_W'(pl + ox + tw); p.tbm = COORD_W'(pt + oy + th);
    p.sc = SCALE_W'(sc);
    return p;
  endfunction

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  task automatic send_pane(logic [SRC_W-1:0] sw, logic [SRC_W-1:0] sh,
                           logic [COORD_W-1:0] l, logic [COORD_W-1:0] t,
                           logic [COORD_W-1:0] r, logic [COORD_W-1:0] b,
                           logic [PAN_W-1:0] px, logic [PAN_W-1:0] py,
                           logic signed [ALIGN_W-1:0] ax, logic signed [ALIGN_W-1:0] ay);
    idle_burst();
    in_src_width = sw; in_src_height = sh;
    in_pane_left = l; in_pane_top = t; in_pane_right = r; in_pane_bottom = b;
    in_pan_centre_x = px; in_pan_centre_y = py;
    in_slack_align_x = ax; in_slack_align_y = ay;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    placements_due.push_back(predict_placement());
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (placements_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(vfc_reg_t idx, longint unsigned val);
    cfg_index = idx; cfg_data = CFG_W'(val); cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REF_WIDTH:  ref_w_reg = val & 14'h3FFF;
      REG_REF_HEIGHT: ref_h_reg = val & 14'h3FFF;
      default:        zoom_reg  = val & 24'hFFFFFF;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic set_mode(longint unsigned rw, longint unsigned rh, longint unsigned z);
    drain();
    write_reg(REG_REF_WIDTH, rw);
    write_reg(REG_REF_HEIGHT, rh);
    write_reg(REG_ZOOM, z);
  endtask

  task automatic send_random_pane(bit well_formed);
    logic [COORD_W-1:0] l, t, r, b;
    logic [SRC_W-1:0] sw, sh;
    logic signed [ALIGN_W-1:0] ax, ay;
    l = COORD_W'($urandom_range(0, 22'h3FFFFF)); t = COORD_W'($urandom_range(0, 22'h3FFFFF));
    r = COORD_W'($urandom_range(0, 22'h3FFFFF)); b = COORD_W'($urandom_range(0, 22'h3FFFFF));
    sw = SRC_W'($urandom_range(0, 16383)); sh = SRC_W'($urandom_range(0, 16383));
    if (well_formed) begin
      if ($urandom_range(0, 1)) begin
        sw = SRC_W'($urandom_range(1, 64)); sh = SRC_W'($urandom_range(1, 64));
      end else begin
        sw = SRC_W'($urandom_range(1, 16383)); sh = SRC_W'($urandom_range(1, 16383));
      end
      l = COORD_W'($urandom_range(0, 22'h200000)); t = COORD_W'($urandom_range(0, 22'h200000));
      r = COORD_W'(l + $urandom_range(1, 22'h3FFFFF - l));
      b = COORD_W'(t + $urandom_range(1, 22'h3FFFFF - t));
    end
    ax = $urandom_range(0, 2) == 0 ? ALIGN_W'($urandom) : ALIGN_W'($urandom_range(0, 65536));
    ay = $urandom_range(0, 2) == 0 ? ALIGN_W'($urandom) : ALIGN_W'($urandom_range(0, 65536));
    send_pane(sw, sh, l, t, r, b, PAN_W'($urandom_range(0, 17'h1FFFF)),
              PAN_W'($urandom_range(0, 65536)), ax, ay);
  endtask

  task automatic test_degenerate();
    send_pane(0, 100, 0, 0, 1000, 1000, 0, 0, 0, 0);
    send_pane(100, 0, 22'h3FFFFF, 0, 22'h3FFFFF, 22'h3FFFFF, 65536, 65536, 65536, 65536);
    send_pane(100, 100, 500, 500, 400, 600, 32768, 32768, -1, 19'sh3FFFF);
    send_pane(100, 100, 500, 500, 600, 500, 32768, 32768, 0, 0);
  endtask

  task automatic test_fit_directed();
    send_pane(100, 100, 0, 0, 100 << FB, 100 << FB, 32768, 32768, 32768, 32768);
    send_pane(16383, 16383, 0, 0, 22'h3FFFFF, 22'h3FFFFF, 0, 65536, 0, 65536);
    send_pane(1, 1, 0, 0, 22'h3FFFFF, 22'h3FFFFF, 65536, 0, -65536, 131072);
    send_pane(16383, 1, 0, 0, 1, 1, 17'h1FFFF, 17'h1FFFF, 19'sh20000, -19'sh40000);
    send_pane(640, 480, 1000, 2000, 1000 + (320 << FB), 2000 + (480 << FB),
              0, 65536, 65536, 0);
  endtask

  task automatic test_zoom_directed();
    send_pane(100, 100, 0, 0, 50 << FB, 50 << FB, 0, 0, 0, 0);
    send_pane(100, 100, 0, 0, 50 << FB, 50 << FB, 65536, 65536, 65536, 65536);
    send_pane(100, 100, 0, 0, 50 << FB, 50 << FB, 17'h1FFFF, 17'h1FFFF, 32768, 32768);
    send_pane(16383, 16383, 0, 0, 22'h3FFFFF, 22'h3FFFFF, 32768, 32768, 32768, 32768);
    send_pane(1, 1, 0, 0, 22'h3FFFFF, 22'h3FFFFF, 32768, 32768, 32768, 32768);
  endtask

  task automatic test_random(int n);
    repeat (n) send_random_pane($urandom_range(0, 9) != 0);
  endtask

  always @(posedge clk) begin
    placement_t e;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (placements_due.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = placements_due.pop_front();
          if (out_crop_left !== e.cl) begin
            $error("crop_left exp %0d got %0d", e.cl, out_crop_left); errors++;
          end
          if (out_crop_top !== e.ct) begin
            $error("crop_top exp %0d got %0d", e.ct, out_crop_top); errors++;
          end
          if (out_crop_right !== e.cr) begin
            $error("crop_right exp %0d got %0d", e.cr, out_crop_right); errors++;
          end
          if (out_crop_bottom !== e.cb) begin
            $error("crop_bottom exp %0d got %0d", e.cb, out_crop_bottom); errors++;
          end
          if (out_target_left !== e.tl) begin
            $error("target_left exp %0d got %0d", e.tl, out_target_left); errors++;
          end
          if (out_target_top !== e.tt) begin
            $error("target_top exp %0d got %0d", e.tt, out_target_top); errors++;
          end
          if (out_target_right !== e.tr) begin
            $error("target_right exp %0d got %0d", e.tr, out_target_right);
            errors++;
          end
          if (out_target_bottom !== e.tbm) begin
            $error("target_bottom exp %0d got %0d", e.tbm, out_target_bottom);
            errors++;
          end
          if (out_screen_scale !== e.sc) begin
            $error("screen_scale exp %0d got %0d", e.sc, out_screen_scale);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready = 1;
      end
    end
  end

  initial begin
    rst_n = 0; cfg_valid = 0; cfg_index = REG_REF_WIDTH; cfg_data = '0; in_valid = 0;
    in_src_width = '0; in_src_height = '0; in_pane_left = '0; in_pane_top = '0;
    in_pane_right = '0; in_pane_bottom = '0; in_pan_centre_x = '0; in_pan_centre_y = '0;
    in_slack_align_x = '0; in_slack_align_y = '0;
    ref_w_reg = 0; ref_h_reg = 0; zoom_reg = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;
    test_degenerate();
    test_fit_directed();
    set_mode(0, 0, 65536);
    test_zoom_directed();
    set_mode(200, 0, 131072);
    test_zoom_directed();
    set_mode(16383, 16383, 24'hFFFFFF);
    test_zoom_directed();
    test_random(200);
    set_mode(50, 16383, 1);
    test_random(200);
    set_mode(1, 1, 3 << 16);
    test_random(200);
    set_mode(0, 0, 0);
    test_random(400);
    set_mode(700, 300, 24'h008000);
    test_random(150);
    gaps_on = 0;
    test_random(200);
    drain();
    $display("covered %0d results over fit, zoom and degenerate panes", results_seen);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
